@@ rtl/tpcr_pkg.sv @@
// ----------------------------------------------------------------------------
// tpcr_pkg
// Shared types and constants for the touch point calibrate and rotate unit.
// ----------------------------------------------------------------------------
package tpcr_pkg;

	localparam int unsigned SAMPLE_W = 12;
	localparam int unsigned COORD_W  = 16;
	localparam int unsigned TURN_W   = 3;
	localparam int unsigned PROD_W   = 2 * COORD_W;
	localparam int unsigned STEP_W   = $clog2(PROD_W);
	localparam int unsigned IDX_W    = 3;
	localparam int unsigned IN_W     = 24;
	localparam int unsigned OUT_W    = 32;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_QUARTER_TURNS = 3'd0;
	localparam logic [IDX_W-1:0] REG_CALIBRATE_ON  = 3'd1;
	localparam logic [IDX_W-1:0] REG_X_RAW_LOW     = 3'd2;
	localparam logic [IDX_W-1:0] REG_X_RAW_HIGH    = 3'd3;
	localparam logic [IDX_W-1:0] REG_Y_RAW_LOW     = 3'd4;
	localparam logic [IDX_W-1:0] REG_Y_RAW_HIGH    = 3'd5;
	localparam logic [IDX_W-1:0] REG_X_SPAN        = 3'd6;
	localparam logic [IDX_W-1:0] REG_Y_SPAN        = 3'd7;

	// reset values
	localparam logic [COORD_W-1:0] RST_X_RAW_HIGH = 16'd319;
	localparam logic [COORD_W-1:0] RST_Y_RAW_HIGH = 16'd479;
	localparam logic [COORD_W-1:0] RST_X_SPAN     = 16'd319;
	localparam logic [COORD_W-1:0] RST_Y_SPAN     = 16'd479;

	// output for an axis with a zero raw range
	localparam logic [COORD_W-1:0] ZERO_RANGE_VAL = 16'hFFFF;

	// rotation codes
	localparam logic [TURN_W-1:0] TURN_0 = 3'd0;
	localparam logic [TURN_W-1:0] TURN_1 = 3'd1;
	localparam logic [TURN_W-1:0] TURN_2 = 3'd2;
	localparam logic [TURN_W-1:0] TURN_3 = 3'd3;

	typedef struct packed {
		logic               start;
		logic [PROD_W-1:0]  dividend;
		logic [COORD_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [COORD_W-1:0] quotient;
	} div_rsp_t;

endpackage

@@ rtl/tpcr_div.sv @@
// ----------------------------------------------------------------------------
// tpcr_div
// Restoring unsigned divider, one quotient bit per cycle, low quotient bits.
// ----------------------------------------------------------------------------
module tpcr_div (
	input  logic               clk,
	input  logic               arst_n,
	input  tpcr_pkg::div_req_t req,
	output tpcr_pkg::div_rsp_t rsp
);

	logic [tpcr_pkg::PROD_W-1:0]  dvd_q;
	logic [tpcr_pkg::COORD_W-1:0] dsr_q;
	logic [tpcr_pkg::COORD_W-1:0] rem_q;
	logic [tpcr_pkg::COORD_W-1:0] quo_q;
	logic [tpcr_pkg::STEP_W-1:0]  cnt_q;
	logic                         busy_q;
	logic                         done_q;

	logic [tpcr_pkg::COORD_W:0]   trial;
	logic [tpcr_pkg::COORD_W:0]   diff;
	logic                         fits;

	// shift the next dividend bit into the partial remainder
	assign trial = {rem_q, dvd_q[tpcr_pkg::PROD_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + tpcr_pkg::STEP_W'(1);
				if (cnt_q == tpcr_pkg::STEP_W'(tpcr_pkg::PROD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[tpcr_pkg::PROD_W-2:0], 1'b0};
			rem_q <= fits ? diff[tpcr_pkg::COORD_W-1:0] : trial[tpcr_pkg::COORD_W-1:0];
			quo_q <= {quo_q[tpcr_pkg::COORD_W-2:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

@@ rtl/touch_point_calibrate_rotate_unit.sv @@
// ----------------------------------------------------------------------------
// touch_point_calibrate_rotate_unit
// Clamps a raw touch sample to the calibrated window, maps it linearly and
// rotates it in quarter turns.
// ----------------------------------------------------------------------------
//  channel   dir   payload                                 transfer when
//  s_*       in    tdata: sample_x[11:0], sample_y[23:12]  s_tvalid & s_tready
//  m_*       out   tdata: out_x[15:0], out_y[31:16]        m_tvalid & m_tready
//  cfg_*     in    cfg_index, cfg_data                     cfg_valid & cfg_ready
//
//  calibration off: the sample goes through the done state into the result register,
//  and no new sample is taken until that state is left; calibration on: per axis
//  a multiply state and a divide on the shared bit-serial divider, the two axes one
//  after the other; a zero raw range skips that axis' divide
//  s_tready is high only while the sequencer is idle; one result register
//  lets a new sample in while the last result still waits on m_tready
//  reset clears the registers to their defaults and the held point to zero
// ----------------------------------------------------------------------------
module touch_point_calibrate_rotate_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [tpcr_pkg::IN_W-1:0]     s_tdata,   // sample_x, sample_y
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tpcr_pkg::OUT_W-1:0]    m_tdata,   // out_x, out_y
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tpcr_pkg::IDX_W-1:0]    cfg_index,
	input  logic [tpcr_pkg::COORD_W-1:0]  cfg_data
);

	typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_DONE} state_t;

	localparam int unsigned CW = tpcr_pkg::COORD_W;

	state_t                       state_q;
	logic                         axis_q;
	logic                         neg_q;
	logic                         out_valid_q;
	logic [tpcr_pkg::OUT_W-1:0]   out_data_q;

	logic [tpcr_pkg::TURN_W-1:0]  quarter_turns_q;
	logic                         calibrate_on_q;
	logic [CW-1:0]                x_raw_low_q, x_raw_high_q, y_raw_low_q, y_raw_high_q;
	logic [CW-1:0]                x_span_q, y_span_q;
	logic [CW-1:0]                held_x_q, held_y_q;
	logic [CW-1:0]                px_q, py_q;

	tpcr_pkg::div_req_t           div_req;
	tpcr_pkg::div_rsp_t           div_rsp;

	logic [CW-1:0]                raw_x, raw_y, clamp_x, clamp_y;
	logic [CW-1:0]                ax_v, ax_lo, ax_hi, ax_span;
	logic [CW:0]                  delta, run;
	logic [CW-1:0]                delta_mag, run_mag;
	logic [CW-1:0]                div_res;
	logic [CW-1:0]                xmax, ymax, rot_x, rot_y;
	logic                         held_nz, out_free;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quarter_turns_q <= tpcr_pkg::TURN_0;
			calibrate_on_q  <= 1'b0;
			x_raw_low_q     <= '0;
			x_raw_high_q    <= tpcr_pkg::RST_X_RAW_HIGH;
			y_raw_low_q     <= '0;
			y_raw_high_q    <= tpcr_pkg::RST_Y_RAW_HIGH;
			x_span_q        <= tpcr_pkg::RST_X_SPAN;
			y_span_q        <= tpcr_pkg::RST_Y_SPAN;
		end else if (cfg_valid) begin
			case (cfg_index)
				tpcr_pkg::REG_QUARTER_TURNS: quarter_turns_q <= cfg_data[tpcr_pkg::TURN_W-1:0];
				tpcr_pkg::REG_CALIBRATE_ON:  calibrate_on_q  <= cfg_data[0];
				tpcr_pkg::REG_X_RAW_LOW:     x_raw_low_q     <= cfg_data;
				tpcr_pkg::REG_X_RAW_HIGH:    x_raw_high_q    <= cfg_data;
				tpcr_pkg::REG_Y_RAW_LOW:     y_raw_low_q     <= cfg_data;
				tpcr_pkg::REG_Y_RAW_HIGH:    y_raw_high_q    <= cfg_data;
				tpcr_pkg::REG_X_SPAN:        x_span_q        <= cfg_data;
				tpcr_pkg::REG_Y_SPAN:        y_span_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// once the held point is nonzero, clamp to the high bound first, then the low bound
	assign raw_x   = {{(CW - tpcr_pkg::SAMPLE_W){1'b0}}, s_tdata[tpcr_pkg::SAMPLE_W-1:0]};
	assign raw_y   = {{(CW - tpcr_pkg::SAMPLE_W){1'b0}},
		s_tdata[2*tpcr_pkg::SAMPLE_W-1:tpcr_pkg::SAMPLE_W]};
	assign held_nz = (held_x_q != '0) || (held_y_q != '0);

	always_comb begin
		clamp_x = raw_x;
		clamp_y = raw_y;
		if (held_nz) begin
			if (clamp_x > x_raw_high_q) clamp_x = x_raw_high_q;
			if (clamp_x < x_raw_low_q)  clamp_x = x_raw_low_q;
			if (clamp_y > y_raw_high_q) clamp_y = y_raw_high_q;
			if (clamp_y < y_raw_low_q)  clamp_y = y_raw_low_q;
		end
	end

	// operands of the axis being mapped
	assign ax_v    = axis_q ? py_q : px_q;
	assign ax_lo   = axis_q ? y_raw_low_q : x_raw_low_q;
	assign ax_hi   = axis_q ? y_raw_high_q : x_raw_high_q;
	assign ax_span = axis_q ? y_span_q : x_span_q;

	assign delta     = {1'b0, ax_v} - {1'b0, ax_lo};
	assign run       = {1'b0, ax_hi} - {1'b0, ax_lo};
	assign delta_mag = delta[CW] ? CW'(-delta) : delta[CW-1:0];
	assign run_mag   = run[CW] ? CW'(-run) : run[CW-1:0];

	// magnitude product goes straight into the divider's dividend register
	assign div_req.start    = (state_q == ST_MUL) && (run != '0);
	assign div_req.dividend = tpcr_pkg::PROD_W'(delta_mag) * tpcr_pkg::PROD_W'(ax_span);
	assign div_req.divisor  = run_mag;

	tpcr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// truncating signed division: restore the sign on the quotient
	assign div_res = neg_q ? CW'(-div_rsp.quotient) : div_rsp.quotient;

	assign xmax = calibrate_on_q ? x_span_q : x_raw_high_q;
	assign ymax = calibrate_on_q ? y_span_q : y_raw_high_q;

	always_comb begin
		case (quarter_turns_q)
			tpcr_pkg::TURN_0: begin
				rot_x = px_q;
				rot_y = py_q;
			end
			tpcr_pkg::TURN_1: begin
				rot_x = py_q;
				rot_y = xmax - px_q;
			end
			tpcr_pkg::TURN_2: begin
				rot_x = xmax - px_q;
				rot_y = ymax - py_q;
			end
			tpcr_pkg::TURN_3: begin
				rot_x = ymax - py_q;
				rot_y = px_q;
			end
			default: begin
				rot_x = held_x_q;
				rot_y = held_y_q;
			end
		endcase
	end

	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= 1'b0;
			out_valid_q <= 1'b0;
			held_x_q    <= '0;
			held_y_q    <= '0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						axis_q  <= 1'b0;
						state_q <= calibrate_on_q ? ST_MUL : ST_DONE;
					end
				end
				ST_MUL: begin
					if (run == '0) begin
						if (axis_q) begin
							state_q <= ST_DONE;
						end
						axis_q <= 1'b1;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						axis_q  <= 1'b1;
						state_q <= axis_q ? ST_DONE : ST_MUL;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						held_x_q    <= rot_x;
						held_y_q    <= rot_y;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working point and result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			px_q <= clamp_x;
			py_q <= clamp_y;
		end
		if (state_q == ST_MUL) begin
			neg_q <= delta[CW] ^ run[CW];
			if (run == '0) begin
				if (axis_q) py_q <= tpcr_pkg::ZERO_RANGE_VAL;
				else        px_q <= tpcr_pkg::ZERO_RANGE_VAL;
			end
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			if (axis_q) py_q <= div_res;
			else        px_q <= div_res;
		end
		if (state_q == ST_DONE && out_free) begin
			out_data_q <= {rot_y, rot_x};
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// the divider is never restarted while it runs
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	// s_tready is low in the cycle after a sample transfer
	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("sample taken while previous one in progress");

	// a newly loaded result matches the held point
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (m_tvalid && m_tdata == {held_y_q, held_x_q}))
		else $error("result does not match held point");

	// divider results only arrive while waiting on them
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV))
		else $error("divider result outside divide state");

endmodule

@@ test/tb_touch_point_calibrate_rotate_unit.sv @@
// ----------------------------------------------------------------------------
// tb_touch_point_calibrate_rotate_unit
// Self-checking bench for the touch point calibrate and rotate unit. A table
// of directed samples and register writes comes first, then random register
// setups, each followed by a burst of random touch samples. Every result is
// compared against an in-bench model of the clamp, linear mapping and
// quarter-turn rotation, or against fixed values for the known directed rows,
// with random gaps on both stream sides except in the last third of the random part.
module tb_touch_point_calibrate_rotate_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SAMPLE_W = tpcr_pkg::SAMPLE_W;
	localparam int unsigned COORD_W  = tpcr_pkg::COORD_W;
	localparam int unsigned TURN_W   = tpcr_pkg::TURN_W;
	localparam int unsigned IDX_W    = tpcr_pkg::IDX_W;
	localparam int unsigned IN_W     = tpcr_pkg::IN_W;
	localparam int unsigned OUT_W    = tpcr_pkg::OUT_W;

	localparam int unsigned RANDOM_SAMPLES = 1530;
	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned SETTLE_CYCLES  = 100;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} point_t;

	typedef enum logic [1:0] {ROW_REG, ROW_PT, ROW_PT_KNOWN} row_kind_t;

	typedef struct packed {
		row_kind_t           kind;
		logic [IDX_W-1:0]    idx;
		logic [COORD_W-1:0]  data;
		logic [SAMPLE_W-1:0] sx;
		logic [SAMPLE_W-1:0] sy;
		logic [COORD_W-1:0]  ex;
		logic [COORD_W-1:0]  ey;
	} stim_row_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [OUT_W-1:0]    m_tdata;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [IDX_W-1:0]    cfg_index;
	logic [COORD_W-1:0]  cfg_data;

	// bench copy of the registers and of the held point
	logic [TURN_W-1:0]   turns_cfg;
	logic                cal_cfg;
	logic [COORD_W-1:0]  x_lo_cfg, x_hi_cfg, y_lo_cfg, y_hi_cfg;
	logic [COORD_W-1:0]  x_span_cfg, y_span_cfg;
	logic [COORD_W-1:0]  last_x, last_y;

	point_t              pending_points[$];
	stim_row_t           directed_rows[$];

	int                  src_idle_pct;
	int                  sink_idle_pct;
	int unsigned         samples_sent;
	int unsigned         directed_samples;
	int unsigned         results_checked;
	int unsigned         reg_writes;
	int unsigned         setups_loaded;
	int unsigned         error_count;
	int unsigned         quiet_cycles;

	touch_point_calibrate_rotate_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [COORD_W-1:0] rnd16();
		logic [31:0] r;
		r = $urandom;
		return r[COORD_W-1:0];
	endfunction

	function automatic logic [COORD_W-1:0] rnd_between(input int unsigned lo,
			input int unsigned hi);
		logic [31:0] r;
		r = $urandom_range(hi, lo);
		return r[COORD_W-1:0];
	endfunction

	function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v, lo, hi);
		logic [COORD_W-1:0] r;
		r = v;
		if (r > hi) r = hi;
		if (r < lo) r = lo;
		return r;
	endfunction

	// exact product, signed division truncating toward zero, kept to 16 bits
	function automatic logic [COORD_W-1:0] scale_coord(input logic [COORD_W-1:0] v, lo, hi,
			span);
		longint run, delta, q;
		run = longint'({48'd0, hi}) - longint'({48'd0, lo});
		delta = longint'({48'd0, v}) - longint'({48'd0, lo});
		if (run == 0) return tpcr_pkg::ZERO_RANGE_VAL;
		q = (delta * longint'({48'd0, span})) / run;
		return q[COORD_W-1:0];
	endfunction

	function automatic point_t next_point(input logic [SAMPLE_W-1:0] sx, sy);
		logic [COORD_W-1:0] rx, ry, xmax, ymax;
		point_t p;
		rx = {4'd0, sx};
		ry = {4'd0, sy};
		if (last_x != '0 || last_y != '0) begin
			rx = clamp_coord(rx, x_lo_cfg, x_hi_cfg);
			ry = clamp_coord(ry, y_lo_cfg, y_hi_cfg);
		end
		if (cal_cfg) begin
			rx = scale_coord(rx, x_lo_cfg, x_hi_cfg, x_span_cfg);
			ry = scale_coord(ry, y_lo_cfg, y_hi_cfg, y_span_cfg);
			xmax = x_span_cfg;
			ymax = y_span_cfg;
		end else begin
			xmax = x_hi_cfg;
			ymax = y_hi_cfg;
		end
		case (turns_cfg)
			tpcr_pkg::TURN_0: begin
				last_x = rx;
				last_y = ry;
			end
			tpcr_pkg::TURN_1: begin
				last_x = ry;
				last_y = xmax - rx;
			end
			tpcr_pkg::TURN_2: begin
				last_x = xmax - rx;
				last_y = ymax - ry;
			end
			tpcr_pkg::TURN_3: begin
				last_x = ymax - ry;
				last_y = rx;
			end
			default: ;	// held point stays
		endcase
		p.x = last_x;
		p.y = last_y;
		return p;
	endfunction

	function automatic void apply_reg(input logic [IDX_W-1:0] idx,
			input logic [COORD_W-1:0] val);
		case (idx)
			tpcr_pkg::REG_QUARTER_TURNS: turns_cfg  = val[TURN_W-1:0];
			tpcr_pkg::REG_CALIBRATE_ON:  cal_cfg    = val[0];
			tpcr_pkg::REG_X_RAW_LOW:     x_lo_cfg   = val;
			tpcr_pkg::REG_X_RAW_HIGH:    x_hi_cfg   = val;
			tpcr_pkg::REG_Y_RAW_LOW:     y_lo_cfg   = val;
			tpcr_pkg::REG_Y_RAW_HIGH:    y_hi_cfg   = val;
			tpcr_pkg::REG_X_SPAN:        x_span_cfg = val;
			tpcr_pkg::REG_Y_SPAN:        y_span_cfg = val;
			default: ;
		endcase
	endfunction

	function automatic void add_reg(input logic [IDX_W-1:0] idx,
			input logic [COORD_W-1:0] val);
		stim_row_t r;
		r = '0;
		r.kind = ROW_REG;
		r.idx = idx;
		r.data = val;
		directed_rows.push_back(r);
	endfunction

	function automatic void add_pt(input logic [SAMPLE_W-1:0] sx, sy);
		stim_row_t r;
		r = '0;
		r.kind = ROW_PT;
		r.sx = sx;
		r.sy = sy;
		directed_rows.push_back(r);
	endfunction

	function automatic void add_known(input logic [SAMPLE_W-1:0] sx, sy,
			input logic [COORD_W-1:0] ex, ey);
		stim_row_t r;
		r = '0;
		r.kind = ROW_PT_KNOWN;
		r.sx = sx;
		r.sy = sy;
		r.ex = ex;
		r.ey = ey;
		directed_rows.push_back(r);
	endfunction

	// partly inside the raw window, with extremes, values just outside and random values
	function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [COORD_W-1:0] lo, hi);
		logic [31:0] r;
		case ($urandom_range(0, 9))
			0: r = 32'd0;
			1: r = 32'd4095;
			2: r = {16'd0, hi} + 32'd1;
			3: r = {16'd0, lo} - 32'd1;
			4, 5, 6, 7: begin
				if (lo <= hi && lo <= 16'd4095)
					r = $urandom_range(lo, (hi > 16'd4095) ? 16'd4095 : hi);
				else
					r = $urandom;
			end
			default: r = $urandom;
		endcase
		return r[SAMPLE_W-1:0];
	endfunction

	function automatic logic [COORD_W-1:0] pick_bound();
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'd4095;
			3: return rnd16();
			default: return rnd_between(0, 4095);
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] pick_span();
		case ($urandom_range(0, 7))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return rnd16();
			default: return rnd_between(0, 1023);
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [COORD_W-1:0] want, got);
		error_count++;
		$display("%0t: mismatch on %s: expected %h, got %h", $time, what, want, got);
	endtask

	// called at a falling edge; returns at a falling edge with cfg_valid low
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, val);
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// called at a falling edge; leaves s_tvalid high for a following sample
	task automatic push_sample(input logic [SAMPLE_W-1:0] sx, sy, input bit known,
			input logic [COORD_W-1:0] ex, ey);
		logic [31:0] noise;
		point_t p;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			noise = $urandom;
			s_tvalid <= 1'b0;
			s_tdata  <= noise[IN_W-1:0];
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {sy, sx};
		do @(posedge clk); while (!s_tready);
		p = next_point(sx, sy);
		if (known) begin
			p.x = ex;
			p.y = ey;
		end
		pending_points.push_back(p);
		samples_sent++;
		@(negedge clk);
	endtask

	// every sample gives a point, so an empty queue means the unit is idle
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_points.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic load_random_setup();
		logic [COORD_W-1:0] xlo, xhi, ylo, yhi, v, t;
		xlo = pick_bound();
		xhi = pick_bound();
		ylo = pick_bound();
		yhi = pick_bound();
		if (xlo > xhi && $urandom_range(0, 9) < 7) begin
			t = xlo;
			xlo = xhi;
			xhi = t;
		end
		if (ylo > yhi && $urandom_range(0, 9) < 7) begin
			t = ylo;
			ylo = yhi;
			yhi = t;
		end
		// upper data bits of the narrow registers are mostly zero, sometimes noise
		v = ($urandom_range(0, 3) == 0) ? rnd16() : 16'd0;
		v[TURN_W-1:0] = TURN_W'(($urandom_range(0, 4) == 0) ? rnd_between(4, 7) :
			rnd_between(0, 3));
		write_reg(tpcr_pkg::REG_QUARTER_TURNS, v);
		v = ($urandom_range(0, 3) == 0) ? rnd16() : 16'd0;
		v[0] = 1'($urandom_range(0, 1));
		write_reg(tpcr_pkg::REG_CALIBRATE_ON, v);
		write_reg(tpcr_pkg::REG_X_RAW_LOW, xlo);
		write_reg(tpcr_pkg::REG_X_RAW_HIGH, xhi);
		write_reg(tpcr_pkg::REG_Y_RAW_LOW, ylo);
		write_reg(tpcr_pkg::REG_Y_RAW_HIGH, yhi);
		write_reg(tpcr_pkg::REG_X_SPAN, pick_span());
		write_reg(tpcr_pkg::REG_Y_SPAN, pick_span());
		setups_loaded++;
	endtask

	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
	end

	always @(posedge clk) begin : result_check
		point_t want_pt;
		point_t got_pt;
		if (arst_n && m_tvalid && m_tready) begin
			got_pt.x = m_tdata[COORD_W-1:0];
			got_pt.y = m_tdata[OUT_W-1:COORD_W];
			if (pending_points.size() == 0) begin
				report_mismatch("out_x of unexpected transfer", '0, got_pt.x);
			end else begin
				want_pt = pending_points.pop_front();
				if (got_pt.x !== want_pt.x) report_mismatch("out_x", want_pt.x, got_pt.x);
				if (got_pt.y !== want_pt.y) report_mismatch("out_y", want_pt.y, got_pt.y);
				results_checked++;
			end
		end
	end

	initial begin : watchdog
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		int unsigned random_samples;
		int mode;
		int burst;
		clk       = 1'b0;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		turns_cfg  = tpcr_pkg::TURN_0;
		cal_cfg    = 1'b0;
		x_lo_cfg   = '0;
		x_hi_cfg   = tpcr_pkg::RST_X_RAW_HIGH;
		y_lo_cfg   = '0;
		y_hi_cfg   = tpcr_pkg::RST_Y_RAW_HIGH;
		x_span_cfg = tpcr_pkg::RST_X_SPAN;
		y_span_cfg = tpcr_pkg::RST_Y_SPAN;
		last_x = '0;
		last_y = '0;
		samples_sent = 0;
		results_checked = 0;
		reg_writes = 0;
		setups_loaded = 0;
		error_count = 0;
		random_samples = 0;
		src_idle_pct = 23;
		sink_idle_pct = 54;

		// raw pass-through while the held point is zero, then clamping
		add_known(12'hFFF, 12'hFFF, 16'hFFF, 16'hFFF);
		add_known(12'hFFF, 12'hFFF, 16'd319, 16'd479);
		add_known(12'd0, 12'd0, 16'd0, 16'd0);
		add_known(12'd100, 12'd200, 16'd100, 16'd200);
		add_reg(tpcr_pkg::REG_QUARTER_TURNS, 16'd1);
		add_pt(12'd100, 12'd200);
		add_reg(tpcr_pkg::REG_QUARTER_TURNS, 16'd2);
		add_pt(12'hFFF, 12'd0);
		add_reg(tpcr_pkg::REG_QUARTER_TURNS, 16'd3);
		add_pt(12'd0, 12'hFFF);
		add_reg(tpcr_pkg::REG_QUARTER_TURNS, 16'hFFFF);
		add_pt(12'd55, 12'd66);
		// identity mapping with the reset window
		add_reg(tpcr_pkg::REG_QUARTER_TURNS, 16'd0);
		add_reg(tpcr_pkg::REG_CALIBRATE_ON, 16'd1);
		add_known(12'd319, 12'd479, 16'd319, 16'd479);
		add_known(12'd0, 12'd0, 16'd0, 16'd0);
		// unclamped sample below the origin maps negative
		add_reg(tpcr_pkg::REG_X_RAW_LOW, 16'd200);
		add_reg(tpcr_pkg::REG_Y_RAW_LOW, 16'd300);
		add_pt(12'd0, 12'd0);
		// zero raw range on x
		add_reg(tpcr_pkg::REG_X_RAW_HIGH, 16'd200);
		add_pt(12'hFFF, 12'hFFF);
		// inverted x window and full-scale y
		add_reg(tpcr_pkg::REG_X_RAW_LOW, 16'd4000);
		add_reg(tpcr_pkg::REG_X_RAW_HIGH, 16'd10);
		add_reg(tpcr_pkg::REG_Y_RAW_LOW, 16'd0);
		add_reg(tpcr_pkg::REG_Y_RAW_HIGH, 16'hFFFF);
		add_reg(tpcr_pkg::REG_X_SPAN, 16'hFFFF);
		add_reg(tpcr_pkg::REG_Y_SPAN, 16'hFFFF);
		add_pt(12'd1000, 12'hFFF);
		add_reg(tpcr_pkg::REG_QUARTER_TURNS, 16'd2);
		add_pt(12'hFFF, 12'd0);
		add_reg(tpcr_pkg::REG_X_SPAN, 16'd0);
		add_reg(tpcr_pkg::REG_Y_SPAN, 16'd0);
		add_reg(tpcr_pkg::REG_QUARTER_TURNS, 16'd1);
		add_pt(12'd2048, 12'd2048);
		// calibration off, inverted y window, subtraction wraps
		add_reg(tpcr_pkg::REG_QUARTER_TURNS, 16'd3);
		add_reg(tpcr_pkg::REG_CALIBRATE_ON, 16'd0);
		add_reg(tpcr_pkg::REG_X_RAW_LOW, 16'd0);
		add_reg(tpcr_pkg::REG_X_RAW_HIGH, 16'hFFFF);
		add_reg(tpcr_pkg::REG_Y_RAW_LOW, 16'hFFFF);
		add_reg(tpcr_pkg::REG_Y_RAW_HIGH, 16'd0);
		add_pt(12'hFFF, 12'd1);
		add_pt(12'd0, 12'hFFF);
		add_reg(tpcr_pkg::REG_QUARTER_TURNS, 16'd6);
		add_pt(12'd1, 12'd2);

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_REG) begin
				drain_results();
				write_reg(directed_rows[i].idx, directed_rows[i].data);
			end else begin
				push_sample(directed_rows[i].sx, directed_rows[i].sy,
					directed_rows[i].kind == ROW_PT_KNOWN,
					directed_rows[i].ex, directed_rows[i].ey);
			end
		end
		directed_samples = samples_sent;

		while (random_samples < RANDOM_SAMPLES) begin
			mode = (random_samples * 3) / RANDOM_SAMPLES;
			drain_results();
			case (mode)
				0: begin
					src_idle_pct = 23;
					sink_idle_pct = 54;
				end
				1: begin
					src_idle_pct = 54;
					sink_idle_pct = 23;
				end
				default: begin
					src_idle_pct = 0;
					sink_idle_pct = 0;
				end
			endcase
			load_random_setup();
			burst = $urandom_range(20, 60);
			repeat (burst) begin
				push_sample(pick_sample(x_lo_cfg, x_hi_cfg), pick_sample(y_lo_cfg, y_hi_cfg),
					1'b0, '0, '0);
				random_samples++;
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d touch samples (%0d directed), %0d points checked, %0d register writes",
			samples_sent, directed_samples, results_checked, reg_writes);
		$display("random part ran %0d register setups under three idling patterns, %0d mismatches",
			setups_loaded, error_count);
		if (error_count == 0 && pending_points.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
